// ----- hw/rtl/csem_pkg.sv -----
`timescale 1ns / 1ps

package csem_pkg;

   localparam int DEF_SLOTS      = 64;
   localparam int DEF_COUNT_BITS = 16;
   localparam int OPCODE_BITS    = 2;
   localparam int ID_BITS        = 7;
   localparam int IN_COUNT_BITS  = 16;
   localparam int STATUS_BITS    = 3;

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_CREATE = 2'd0,
      OP_WAIT   = 2'd1,
      OP_SIGNAL = 2'd2,
      OP_DELETE = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK          = 3'd0,
      ST_BAD_ID      = 3'd1,
      ST_NOT_EXIST   = 3'd2,
      ST_WOULD_BLOCK = 3'd3,
      ST_NO_SLOT     = 3'd4
   } status_type;

endpackage

// ----- hw/rtl/csem_free_find.sv -----
`timescale 1ns / 1ps

module csem_free_find import csem_pkg::*; #(
   parameter int SLOTS   = DEF_SLOTS,
   parameter int SLOT_IW = 6
) (
   input  logic [SLOTS-1:0]   active,
   output logic               found,
   output logic [SLOT_IW-1:0] index
);

   always_comb begin
      found = 1'b0;
      index = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!active[i]) begin
            found = 1'b1;
            index = SLOT_IW'(i);
         end
      end
   end

endmodule

// ----- hw/rtl/csem_store.sv -----
`timescale 1ns / 1ps

module csem_store import csem_pkg::*; #(
   parameter int SLOTS      = DEF_SLOTS,
   parameter int COUNT_BITS = DEF_COUNT_BITS,
   parameter int SLOT_IW    = 6
) (
   input  logic                    clock,
   input  logic                    rd_en,
   input  logic [SLOT_IW-1:0]      rd_addr,
   output logic [2*COUNT_BITS-1:0] rd_data,
   input  logic                    wr_en,
   input  logic [SLOT_IW-1:0]      wr_addr,
   input  logic [2*COUNT_BITS-1:0] wr_data
);

   logic [2*COUNT_BITS-1:0] mem [SLOTS];
   logic [2*COUNT_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/counting_semaphore_table.sv -----
`timescale 1ns / 1ps

// Table of counting semaphores driven by one command per transfer.
// The request channel (req_*) carries an opcode (create, wait, signal,
// delete), a one-based id and, for create, the initial count and ceiling.
// The response channel (rsp_*) returns a status code and, for a
// successful create, the id given out; every request yields exactly one
// response, in order.
// A request transfer also reads the slot's count and ceiling from the
// synchronous count memory and latches the lowest free slot; the update
// state then does the read-modify-write and loads the response register.
// No further request is taken until that update is done, and the
// response is driven from the response register.
// A new request is accepted while a response still waits; if the
// receiver stalls, the second command holds in its update state until the
// waiting response is taken. Reset clears all active marks and empties
// the response register; count memory contents are not cleared.

module counting_semaphore_table import csem_pkg::*; #(
   parameter int SLOTS      = DEF_SLOTS,
   parameter int COUNT_BITS = DEF_COUNT_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [OPCODE_BITS-1:0]   req_opcode,
   input  logic [ID_BITS-1:0]       req_sem_id,
   input  logic [IN_COUNT_BITS-1:0] req_initial_count,
   input  logic [IN_COUNT_BITS-1:0] req_max_count,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [STATUS_BITS-1:0]   rsp_status,
   output logic [ID_BITS-1:0]       rsp_new_id
);

   localparam int SlotIw = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [COUNT_BITS-1:0] CountTop = '1;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type                state_ff, state_in;
   opcode_type               op_ff;
   logic                     id_ok_ff;
   logic [SlotIw-1:0]        slot_ff;
   logic [IN_COUNT_BITS-1:0] init_ff, max_ff;
   logic                     free_found_ff;
   logic [SlotIw-1:0]        free_idx_ff;
   logic [SLOTS-1:0]         active_ff, active_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic [ID_BITS-1:0]       rsp_new_id_ff, rsp_new_id_in;

   logic                     req_fire, go, req_id_ok;
   logic [SlotIw-1:0]        req_slot;
   logic                     free_found;
   logic [SlotIw-1:0]        free_idx;
   logic [2*COUNT_BITS-1:0]  rd_data, wr_data;
   logic                     wr_en;
   logic [SlotIw-1:0]        wr_addr;
   logic [COUNT_BITS-1:0]    cur_count, cur_limit;
   logic [COUNT_BITS-1:0]    fit_init, fit_max;

   function automatic logic [COUNT_BITS-1:0] fit_count(input logic [IN_COUNT_BITS-1:0] v);
      logic [32:0] ext_v;
      logic [32:0] top_v;
      ext_v = 33'(v);
      top_v = 33'(CountTop);
      fit_count = (ext_v > top_v) ? CountTop : COUNT_BITS'(ext_v);
   endfunction

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign go        = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign req_id_ok = (req_sem_id != '0) && (req_sem_id <= ID_BITS'(SLOTS));
   assign req_slot  = SlotIw'(req_sem_id - ID_BITS'(1));

   csem_free_find #(
      .SLOTS   (SLOTS),
      .SLOT_IW (SlotIw)
   ) u_free_find (
      .active (active_ff),
      .found  (free_found),
      .index  (free_idx)
   );

   csem_store #(
      .SLOTS      (SLOTS),
      .COUNT_BITS (COUNT_BITS),
      .SLOT_IW    (SlotIw)
   ) u_store (
      .clock   (clock),
      .rd_en   (req_fire),
      .rd_addr (req_slot),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign cur_count = rd_data[COUNT_BITS-1:0];
   assign cur_limit = rd_data[2*COUNT_BITS-1:COUNT_BITS];
   assign fit_init  = fit_count(init_ff);
   assign fit_max   = fit_count(max_ff);

   always_comb begin
      state_in      = state_ff;
      active_in     = active_ff;
      wr_en         = 1'b0;
      wr_addr       = slot_ff;
      wr_data       = {cur_limit, cur_count};
      rsp_status_in = rsp_status_ff;
      rsp_new_id_in = rsp_new_id_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (go) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_new_id_in = '0;
               unique case (op_ff)
                  OP_CREATE: begin
                     if (free_found_ff) begin
                        active_in[free_idx_ff] = 1'b1;
                        wr_en         = 1'b1;
                        wr_addr       = free_idx_ff;
                        wr_data       = {fit_max, fit_init};
                        rsp_new_id_in = ID_BITS'(free_idx_ff) + ID_BITS'(1);
                     end else begin
                        rsp_status_in = ST_NO_SLOT;
                     end
                  end
                  OP_DELETE: begin
                     if (!id_ok_ff) begin
                        rsp_status_in = ST_BAD_ID;
                     end else begin
                        active_in[slot_ff] = 1'b0;
                     end
                  end
                  OP_WAIT: begin
                     if (!id_ok_ff) begin
                        rsp_status_in = ST_BAD_ID;
                     end else if (!active_ff[slot_ff]) begin
                        rsp_status_in = ST_NOT_EXIST;
                     end else if (cur_count != '0) begin
                        wr_en   = 1'b1;
                        wr_data = {cur_limit, cur_count - COUNT_BITS'(1)};
                     end else begin
                        rsp_status_in = ST_WOULD_BLOCK;
                     end
                  end
                  OP_SIGNAL: begin
                     if (!id_ok_ff) begin
                        rsp_status_in = ST_BAD_ID;
                     end else if (!active_ff[slot_ff]) begin
                        rsp_status_in = ST_NOT_EXIST;
                     end else if (cur_count < cur_limit) begin
                        wr_en   = 1'b1;
                        wr_data = {cur_limit, cur_count + COUNT_BITS'(1)};
                     end
                  end
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff         <= opcode_type'(req_opcode);
         id_ok_ff      <= req_id_ok;
         slot_ff       <= req_slot;
         init_ff       <= req_initial_count;
         max_ff        <= req_max_count;
         free_found_ff <= free_found;
         free_idx_ff   <= free_idx;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_new_id_ff <= rsp_new_id_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_new_id = rsp_new_id_ff;

   a_exec_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC) && rsp_valid_ff && !rsp_ready |=> (state_ff == S_EXEC))
      else $error("update step advanced while a response was still waiting");

   a_write_only_in_exec: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> go)
      else $error("count memory written outside the update step");

   a_id_only_on_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != ST_OK) |-> (rsp_new_id_ff == '0))
      else $error("nonzero id returned with a failing status");

   a_no_slot_means_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == ST_NO_SLOT) |-> ($countones(active_ff) == SLOTS))
      else $error("no-free-slot status reported while a slot is free");

endmodule
